FILE: hw/rtl/pvp_pkg.sv
package pvp_pkg;

    localparam int SW       = 32;
    localparam int FB       = 16;
    localparam int AW       = 24;
    localparam int ATB      = 24;
    localparam int CSTEPS   = 28;
    localparam int NSTEPS   = 6;
    localparam int NORM_TOP = 59;
    localparam int RADW     = 2 * SW;
    localparam int REMW     = SW + 2;
    localparam int MULW     = 7;
    localparam int DIVW     = SW + MULW + FB;
    localparam int XW       = 64;
    localparam int ZW       = 34;
    localparam int NW       = 31;
    localparam int ADDRW    = 5;
    localparam int PW       = 32;

    localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(90) <<< ATB;
    localparam logic signed [AW-1:0] ANG_LIM   = AW'(90) <<< FB;
    localparam int RND_SH = ATB - FB + 1;
    localparam logic signed [ZW-1:0] RND_ADD = ZW'(1) <<< (ATB - FB);

    typedef enum logic [2:0] {
        REG_FRACTIONAL = 3'd0,
        REG_ISRC       = 3'd1,
        REG_ASRC       = 3'd2,
        REG_TSRC       = 3'd3,
        REG_THRESHOLD  = 3'd4,
        REG_DEBIAS     = 3'd5,
        REG_QNOISE     = 3'd6,
        REG_UNOISE     = 3'd7
    } reg_idx_t;

    localparam logic [1:0] SRC_NONE     = 2'd0;
    localparam logic [1:0] SRC_CURRENT  = 2'd1;
    localparam logic [1:0] SRC_COMPUTED = 2'd2;
    // unused code, behaves as none
    localparam logic [1:0] SRC_SPARE    = 2'd3;

    localparam logic [1:0] TH_NONE    = 2'd0;
    localparam logic [1:0] TH_CURRENT = 2'd1;
    localparam logic [1:0] TH_TOTAL   = 2'd2;
    localparam logic [1:0] TH_POLAR   = 2'd3;

    typedef struct packed {
        logic [RADW-1:0] rad;
        logic [REMW-1:0] rem;
        logic [SW-1:0]   root;
        logic            tag;
    } sqrt_t;

    typedef struct packed {
        logic [DIVW-1:0] num;
        logic [SW-1:0]   rem;
        logic [SW-1:0]   den;
        logic            tag;
    } div_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [SW-1:0] cur;
        logic                 cur_ok;
        logic signed [SW-1:0] ival;
        logic                 i_ok;
        logic                 qu_ok;
        logic                 zero;
    } side_t;

    function automatic logic [XW-1:0] mag_x(input logic signed [XW-1:0] v);
        mag_x = v[XW-1] ? (~v + XW'(1)) : v;
    endfunction

    // atan(2^-i) in degrees, scaled by 2^24
    function automatic logic signed [ZW-1:0] atan_deg(input int idx);
        logic signed [ZW-1:0] r;
        case (idx)
            0:  r = ZW'(754974720);
            1:  r = ZW'(445687602);
            2:  r = ZW'(235489088);
            3:  r = ZW'(119537938);
            4:  r = ZW'(60000934);
            5:  r = ZW'(30029717);
            6:  r = ZW'(15018523);
            7:  r = ZW'(7509720);
            8:  r = ZW'(3754917);
            9:  r = ZW'(1877466);
            10: r = ZW'(938734);
            11: r = ZW'(469367);
            12: r = ZW'(234684);
            13: r = ZW'(117342);
            14: r = ZW'(58671);
            15: r = ZW'(29335);
            16: r = ZW'(14668);
            17: r = ZW'(7334);
            18: r = ZW'(3667);
            19: r = ZW'(1833);
            20: r = ZW'(917);
            21: r = ZW'(458);
            22: r = ZW'(229);
            23: r = ZW'(115);
            24: r = ZW'(57);
            25: r = ZW'(29);
            26: r = ZW'(14);
            27: r = ZW'(7);
            default: r = '0;
        endcase
        atan_deg = r;
    endfunction

endpackage

FILE: hw/rtl/pvp_sqrt_cell.sv
module pvp_sqrt_cell (
    input  logic          clk,
    input  logic          en,
    input  pvp_pkg::sqrt_t d_in,
    output pvp_pkg::sqrt_t d_out
);

    pvp_pkg::sqrt_t data_reg;
    pvp_pkg::sqrt_t data_next;
    logic [pvp_pkg::REMW+1:0] trial;
    logic [pvp_pkg::REMW+1:0] tsub;
    logic [pvp_pkg::REMW+1:0] diff;
    logic                     ge;

    always_comb
    begin
        trial = {d_in.rem, d_in.rad[pvp_pkg::RADW-1 -: 2]};
        tsub  = {2'b00, d_in.root, 2'b01};
        diff  = trial - tsub;
        ge    = trial >= tsub;
        data_next.rad  = {d_in.rad[pvp_pkg::RADW-3:0], 2'b00};
        data_next.rem  = ge ? diff[pvp_pkg::REMW-1:0] : trial[pvp_pkg::REMW-1:0];
        data_next.root = {d_in.root[pvp_pkg::SW-2:0], ge};
        data_next.tag  = d_in.tag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign d_out = data_reg;

endmodule

FILE: hw/rtl/pvp_div_cell.sv
module pvp_div_cell (
    input  logic         clk,
    input  logic         en,
    input  pvp_pkg::div_t d_in,
    output pvp_pkg::div_t d_out
);

    pvp_pkg::div_t data_reg;
    pvp_pkg::div_t data_next;
    logic [pvp_pkg::SW:0] rem2;
    logic [pvp_pkg::SW:0] diff;
    logic                 ge;

    always_comb
    begin
        rem2 = {d_in.rem, d_in.num[pvp_pkg::DIVW-1]};
        diff = rem2 - {1'b0, d_in.den};
        ge   = rem2 >= {1'b0, d_in.den};
        data_next.num = {d_in.num[pvp_pkg::DIVW-2:0], ge};
        data_next.rem = ge ? diff[pvp_pkg::SW-1:0] : rem2[pvp_pkg::SW-1:0];
        data_next.den = d_in.den;
        data_next.tag = d_in.tag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign d_out = data_reg;

endmodule

FILE: hw/rtl/pvp_norm_cell.sv
module pvp_norm_cell #(
    parameter int STEP = 1
) (
    input  logic         clk,
    input  logic         en,
    input  pvp_pkg::vec_t d_in,
    output pvp_pkg::vec_t d_out
);

    pvp_pkg::vec_t data_reg;
    pvp_pkg::vec_t data_next;
    logic [pvp_pkg::XW-1:0] mx;
    logic [pvp_pkg::XW-1:0] my;
    logic                   small_both;

    always_comb
    begin
        mx = pvp_pkg::mag_x(d_in.x);
        my = pvp_pkg::mag_x(d_in.y);
        small_both = ((mx >> (pvp_pkg::NORM_TOP - STEP)) == '0) &&
                     ((my >> (pvp_pkg::NORM_TOP - STEP)) == '0);
        data_next.x = small_both ? (d_in.x <<< STEP) : d_in.x;
        data_next.y = small_both ? (d_in.y <<< STEP) : d_in.y;
        data_next.z = d_in.z;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign d_out = data_reg;

endmodule

FILE: hw/rtl/pvp_cordic_cell.sv
module pvp_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic         clk,
    input  logic         en,
    input  pvp_pkg::vec_t d_in,
    output pvp_pkg::vec_t d_out
);

    localparam logic signed [pvp_pkg::ZW-1:0] ATAN = pvp_pkg::atan_deg(IDX);

    pvp_pkg::vec_t data_reg;
    pvp_pkg::vec_t data_next;
    logic signed [pvp_pkg::XW-1:0] xs;
    logic signed [pvp_pkg::XW-1:0] ys;

    always_comb
    begin
        xs = $signed(d_in.x) >>> IDX;
        ys = $signed(d_in.y) >>> IDX;
        if (!d_in.y[pvp_pkg::XW-1])
        begin
            data_next.x = $signed(d_in.x) + ys;
            data_next.y = $signed(d_in.y) - xs;
            data_next.z = $signed(d_in.z) + ATAN;
        end
        else
        begin
            data_next.x = $signed(d_in.x) - ys;
            data_next.y = $signed(d_in.y) + xs;
            data_next.z = $signed(d_in.z) - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign d_out = data_reg;

endmodule

FILE: hw/rtl/polarization_vector_pixel.sv
// Throughput: one pixel per cycle; square root (32 cells), divider (55 cells)
// and CORDIC (6 normalize + 28 rotate cells) are all fully pipelined rows.
// The whole pipeline stalls only while a result waits on out_ready.
// Reset (rst_n low, async) clears the configuration registers and the
// pipeline valid bits; data registers are not reset.
module polarization_vector_pixel (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pvp_pkg::ADDRW-1:0]      paddr,
    input  logic [pvp_pkg::PW-1:0]         pwdata,
    output logic [pvp_pkg::PW-1:0]         prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [pvp_pkg::SW-1:0]  q_sample,
    input  logic                           q_ok,
    input  logic signed [pvp_pkg::SW-1:0]  u_sample,
    input  logic                           u_ok,
    input  logic signed [pvp_pkg::SW-1:0]  i_sample,
    input  logic                           i_ok,
    input  logic signed [pvp_pkg::SW-1:0]  cur_sample,
    input  logic                           cur_ok,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [pvp_pkg::SW-1:0]  intensity_out,
    output logic                           intensity_ok,
    output logic signed [pvp_pkg::AW-1:0]  angle_out,
    output logic                           angle_ok
);

    localparam int SW      = pvp_pkg::SW;
    localparam int AW      = pvp_pkg::AW;
    localparam int DIVW    = pvp_pkg::DIVW;
    localparam int NW      = pvp_pkg::NW;
    localparam int CSTEPS  = pvp_pkg::CSTEPS;
    localparam int NSTEPS  = pvp_pkg::NSTEPS;
    localparam int SQ_ST   = 3 + SW;
    localparam int LAT     = SQ_ST + 1 + DIVW + 2;
    localparam int ANG_ST  = 1 + NSTEPS + CSTEPS + 1;
    localparam int ANG_DLY = LAT - 1 - ANG_ST;
    localparam int ANG_MAX_C = (1 << (AW - 1)) - 1;

    // configuration
    logic                 cfg_frac_reg;
    logic [1:0]           cfg_isrc_reg;
    logic [1:0]           cfg_asrc_reg;
    logic [1:0]           cfg_tsrc_reg;
    logic signed [SW-1:0] cfg_thr_reg;
    logic                 cfg_debias_reg;
    logic [NW-1:0]        cfg_qn_reg;
    logic [NW-1:0]        cfg_un_reg;
    logic                 cfg_wr;
    pvp_pkg::reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = pvp_pkg::reg_idx_t'(paddr[pvp_pkg::ADDRW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_frac_reg   <= 1'b0;
            cfg_isrc_reg   <= '0;
            cfg_asrc_reg   <= '0;
            cfg_tsrc_reg   <= '0;
            cfg_thr_reg    <= '0;
            cfg_debias_reg <= 1'b0;
            cfg_qn_reg     <= '0;
            cfg_un_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                pvp_pkg::REG_FRACTIONAL: cfg_frac_reg   <= pwdata[0];
                pvp_pkg::REG_ISRC:       cfg_isrc_reg   <= pwdata[1:0];
                pvp_pkg::REG_ASRC:       cfg_asrc_reg   <= pwdata[1:0];
                pvp_pkg::REG_TSRC:       cfg_tsrc_reg   <= pwdata[1:0];
                pvp_pkg::REG_THRESHOLD:  cfg_thr_reg    <= pwdata[SW-1:0];
                pvp_pkg::REG_DEBIAS:     cfg_debias_reg <= pwdata[0];
                pvp_pkg::REG_QNOISE:     cfg_qn_reg     <= pwdata[NW-1:0];
                pvp_pkg::REG_UNOISE:     cfg_un_reg     <= pwdata[NW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            pvp_pkg::REG_FRACTIONAL: prdata = {{(pvp_pkg::PW-1){1'b0}}, cfg_frac_reg};
            pvp_pkg::REG_ISRC:       prdata = {{(pvp_pkg::PW-2){1'b0}}, cfg_isrc_reg};
            pvp_pkg::REG_ASRC:       prdata = {{(pvp_pkg::PW-2){1'b0}}, cfg_asrc_reg};
            pvp_pkg::REG_TSRC:       prdata = {{(pvp_pkg::PW-2){1'b0}}, cfg_tsrc_reg};
            pvp_pkg::REG_THRESHOLD:  prdata = cfg_thr_reg;
            pvp_pkg::REG_DEBIAS:     prdata = {{(pvp_pkg::PW-1){1'b0}}, cfg_debias_reg};
            pvp_pkg::REG_QNOISE:     prdata = {1'b0, cfg_qn_reg};
            pvp_pkg::REG_UNOISE:     prdata = {1'b0, cfg_un_reg};
            default:                 prdata = '0;
        endcase
    end

    // pipeline control
    logic       adv;
    logic [LAT-1:0] vld_reg;

    assign adv       = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // stage 0: capture, magnitudes
    logic signed [SW-1:0] q0_reg, u0_reg;
    logic [SW-1:0]        qm0_reg, um0_reg;
    pvp_pkg::side_t       side_reg [0:LAT-2];
    pvp_pkg::side_t       side_next;

    always_comb
    begin
        side_next.cur    = cur_sample;
        side_next.cur_ok = cur_ok;
        side_next.ival   = i_sample;
        side_next.i_ok   = i_ok;
        side_next.qu_ok  = q_ok && u_ok;
        side_next.zero   = (q_sample == '0) && (u_sample == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q0_reg  <= q_sample;
            u0_reg  <= u_sample;
            qm0_reg <= q_sample[SW-1] ? (~q_sample + SW'(1)) : q_sample;
            um0_reg <= u_sample[SW-1] ? (~u_sample + SW'(1)) : u_sample;
            side_reg[0] <= side_next;
            for (int k = 1; k < LAT - 1; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // stage 1: squares, vector pre-rotation
    logic [2*SW-1:0] qq1_reg, uu1_reg;
    logic [2*NW-1:0] nq1_reg, nu1_reg;
    pvp_pkg::vec_t   vec1_reg;
    pvp_pkg::vec_t   vec1_next;
    logic signed [pvp_pkg::XW-1:0] qx, ux;

    always_comb
    begin
        qx = pvp_pkg::XW'(q0_reg);
        ux = pvp_pkg::XW'(u0_reg);
        vec1_next.x = qx;
        vec1_next.y = ux;
        vec1_next.z = '0;
        if (q0_reg[SW-1])
        begin
            if (!u0_reg[SW-1])
            begin
                vec1_next.x = ux;
                vec1_next.y = -qx;
                vec1_next.z = pvp_pkg::Z_QUARTER;
            end
            else
            begin
                vec1_next.x = -ux;
                vec1_next.y = qx;
                vec1_next.z = -pvp_pkg::Z_QUARTER;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qq1_reg  <= qm0_reg * qm0_reg;
            uu1_reg  <= um0_reg * um0_reg;
            nq1_reg  <= cfg_qn_reg * cfg_qn_reg;
            nu1_reg  <= cfg_un_reg * cfg_un_reg;
            vec1_reg <= vec1_next;
        end
    end

    // stage 2: 2Q^2 + 2U^2 and noise term
    logic [2*SW:0]   a2_reg;
    logic [2*NW:0]   b2_reg;
    logic [2*SW:0]   sum2;

    assign sum2 = {1'b0, qq1_reg} + {1'b0, uu1_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a2_reg <= {sum2[2*SW-1:0], 1'b0};
            b2_reg <= cfg_debias_reg ? ({1'b0, nq1_reg} + {1'b0, nu1_reg}) : '0;
        end
    end

    // stage 3: radicand
    pvp_pkg::sqrt_t sq [0:SW];
    pvp_pkg::sqrt_t sq0_next;
    logic [2*SW:0]  diff3;
    logic [2*SW:0]  b3;

    always_comb
    begin
        b3    = (2*SW+1)'(b2_reg);
        diff3 = a2_reg - b3;
        sq0_next.rad  = diff3[2*SW:1];
        sq0_next.rem  = '0;
        sq0_next.root = '0;
        sq0_next.tag  = side_reg[2].qu_ok && (b3 <= a2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq[0] <= sq0_next;
        end
    end

    for (genvar k = 0; k < SW; k++)
    begin : g_sqrt
        pvp_sqrt_cell u_cell (
            .clk   (clk),
            .en    (adv),
            .d_in  (sq[k]),
            .d_out (sq[k+1])
        );
    end

    // divider setup: PI*100*2^FB / |I|, or PI / 1 when not fractional
    pvp_pkg::div_t  dv [0:DIVW];
    pvp_pkg::div_t  dv0_next;
    logic [SW+pvp_pkg::MULW-1:0] p100;
    pvp_pkg::side_t sd_sq;

    always_comb
    begin
        sd_sq = side_reg[SQ_ST];
        p100  = sq[SW].root * pvp_pkg::MULW'(100);
        dv0_next.rem = '0;
        if (cfg_frac_reg)
        begin
            dv0_next.num = {p100, {pvp_pkg::FB{1'b0}}};
            dv0_next.den = sd_sq.ival[SW-1] ? (~sd_sq.ival + SW'(1)) : sd_sq.ival;
            dv0_next.tag = sq[SW].tag && sd_sq.i_ok && (sd_sq.ival != '0);
        end
        else
        begin
            dv0_next.num = DIVW'(sq[SW].root);
            dv0_next.den = SW'(1);
            dv0_next.tag = sq[SW].tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv[0] <= dv0_next;
        end
    end

    for (genvar k = 0; k < DIVW; k++)
    begin : g_div
        pvp_div_cell u_cell (
            .clk   (clk),
            .en    (adv),
            .d_in  (dv[k]),
            .d_out (dv[k+1])
        );
    end

    // angle path
    pvp_pkg::vec_t vn [0:NSTEPS];
    pvp_pkg::vec_t vc [0:CSTEPS];

    assign vn[0] = vec1_reg;

    for (genvar j = 0; j < NSTEPS; j++)
    begin : g_norm
        pvp_norm_cell #(
            .STEP (1 << (NSTEPS - 1 - j))
        ) u_cell (
            .clk   (clk),
            .en    (adv),
            .d_in  (vn[j]),
            .d_out (vn[j+1])
        );
    end

    assign vc[0] = vn[NSTEPS];

    for (genvar i = 0; i < CSTEPS; i++)
    begin : g_cordic
        pvp_cordic_cell #(
            .IDX (i)
        ) u_cell (
            .clk   (clk),
            .en    (adv),
            .d_in  (vc[i]),
            .d_out (vc[i+1])
        );
    end

    logic signed [AW-1:0]         ang_reg [0:ANG_DLY-1];
    logic signed [AW-1:0]         ang_next;
    logic signed [pvp_pkg::ZW-1:0] zr;

    always_comb
    begin
        zr = ($signed(vc[CSTEPS].z) + pvp_pkg::RND_ADD) >>> pvp_pkg::RND_SH;
        if (side_reg[ANG_ST-1].zero)
        begin
            ang_next = '0;
        end
        else if (zr > pvp_pkg::ZW'(pvp_pkg::ANG_LIM))
        begin
            ang_next = pvp_pkg::ANG_LIM;
        end
        else if (zr < -pvp_pkg::ZW'(pvp_pkg::ANG_LIM))
        begin
            ang_next = -pvp_pkg::ANG_LIM;
        end
        else
        begin
            ang_next = zr[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ang_reg[0] <= ang_next;
            for (int k = 1; k < ANG_DLY; k++)
            begin
                ang_reg[k] <= ang_reg[k-1];
            end
        end
    end

    // final: saturation, threshold, masking
    pvp_pkg::side_t       sd;
    logic [DIVW-1:0]      qv;
    logic                 neg;
    logic                 big;
    logic signed [SW-1:0] pi;
    logic                 pi_ok;
    logic signed [SW-1:0] tv;
    logic                 tok;
    logic                 pass;
    logic signed [SW-1:0] iout_next;
    logic                 iflag_next;
    logic signed [AW-1:0] aout_next;
    logic                 aflag_next;
    logic signed [SW-1:0] imax;
    logic signed [SW-1:0] imin;
    logic signed [SW-1:0] amax_w;
    logic signed [SW-1:0] amin_w;

    always_comb
    begin
        sd    = side_reg[LAT-2];
        qv    = dv[DIVW].num;
        pi_ok = dv[DIVW].tag;
        neg   = cfg_frac_reg && sd.ival[SW-1];
        big   = |qv[DIVW-1:SW-1];
        imax  = {1'b0, {(SW-1){1'b1}}};
        imin  = {1'b1, {(SW-1){1'b0}}};
        if (neg)
        begin
            pi = big ? imin : -$signed(qv[SW-1:0]);
        end
        else
        begin
            pi = big ? imax : $signed(qv[SW-1:0]);
        end

        case (cfg_tsrc_reg)
            pvp_pkg::TH_CURRENT:
            begin
                tok = sd.cur_ok;
                tv  = sd.cur;
            end
            pvp_pkg::TH_TOTAL:
            begin
                tok = sd.i_ok;
                tv  = sd.ival;
            end
            pvp_pkg::TH_POLAR:
            begin
                tok = pi_ok;
                tv  = pi;
            end
            default:
            begin
                tok = 1'b0;
                tv  = '0;
            end
        endcase
        pass = (cfg_tsrc_reg == pvp_pkg::TH_NONE) || (tok && (tv >= cfg_thr_reg));

        iflag_next = 1'b0;
        iout_next  = '0;
        case (cfg_isrc_reg)
            pvp_pkg::SRC_CURRENT:
            begin
                iflag_next = sd.cur_ok && pass;
                iout_next  = sd.cur;
            end
            pvp_pkg::SRC_COMPUTED:
            begin
                if (cfg_tsrc_reg == pvp_pkg::TH_POLAR)
                begin
                    iflag_next = pi_ok && (pi >= cfg_thr_reg);
                end
                else
                begin
                    iflag_next = pi_ok && ((cfg_tsrc_reg == pvp_pkg::TH_NONE) ||
                                 !(tok && (tv < cfg_thr_reg)));
                end
                iout_next = pi;
            end
            default: ;
        endcase

        amax_w     = SW'(ANG_MAX_C);
        amin_w     = -amax_w - SW'(1);
        aflag_next = 1'b0;
        aout_next  = '0;
        case (cfg_asrc_reg)
            pvp_pkg::SRC_CURRENT:
            begin
                aflag_next = sd.cur_ok && pass;
                if (sd.cur > amax_w)
                begin
                    aout_next = amax_w[AW-1:0];
                end
                else if (sd.cur < amin_w)
                begin
                    aout_next = amin_w[AW-1:0];
                end
                else
                begin
                    aout_next = sd.cur[AW-1:0];
                end
            end
            pvp_pkg::SRC_COMPUTED:
            begin
                aflag_next = sd.qu_ok && pass;
                aout_next  = ang_reg[ANG_DLY-1];
            end
            default: ;
        endcase
        if (!iflag_next)
        begin
            iout_next = '0;
        end
        if (!aflag_next)
        begin
            aout_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            intensity_out <= iout_next;
            intensity_ok  <= iflag_next;
            angle_out     <= aout_next;
            angle_ok      <= aflag_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_iout_masked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !intensity_ok |-> intensity_out == '0)
        else $error("intensity not zeroed when invalid");

    a_aout_masked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !angle_ok |-> angle_out == '0)
        else $error("angle not zeroed when invalid");

    a_pipe_drain: assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[LAT-2] |=> out_valid)
        else $error("item lost before output register");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");
`endif

endmodule
